FILE: design/ttms_pkg.sv
// Shared types, constants and helpers of the two-axis trapezoid motion step.
package ttms_pkg;

   typedef struct packed {
      logic               kind;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
      logic signed [31:0] final_speed_x;
      logic signed [31:0] final_speed_y;
   } req_type;

   typedef struct packed {
      logic signed [31:0] accel_x;
      logic signed [31:0] accel_y;
      logic signed [31:0] speed_x;
      logic signed [31:0] speed_y;
      logic signed [31:0] left_x;
      logic signed [31:0] left_y;
      logic               moving;
      logic               finished;
   } rsp_type;

   localparam logic [1:0] CSR_ACCEL_LIMIT = 2'd0;
   localparam logic [1:0] CSR_DECEL_LIMIT = 2'd1;
   localparam logic [1:0] CSR_SPEED_LIMIT = 2'd2;
   localparam logic [1:0] CSR_TICK_LENGTH = 2'd3;

   localparam logic KIND_LOAD = 1'b0;

   localparam logic [30:0] ACCEL_RESET = 31'd65536;
   localparam logic [30:0] DECEL_RESET = 31'd65536;
   localparam logic [30:0] SPEED_RESET = 31'd65536;
   localparam logic [16:0] TICK_RESET  = 17'd655;

   localparam logic [40:0] DIST_CAP = 41'h100_0000_0000;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DECODE, ST_LOAD, ST_MUL_VMDT, ST_MUL_ADT, ST_TEST, ST_IDLE_TICK,
      ST_PICK, ST_MUL_SDT, ST_MUL_SS, ST_MUL_GG, ST_MUL_VV, ST_TG_GO, ST_TG_WAIT,
      ST_AD_GO, ST_AD_WAIT, ST_DD_GO, ST_DD_WAIT, ST_DECIDE, ST_MUL_ACC,
      ST_VEL_STEP, ST_VEL_NEW, ST_VSUM, ST_MUL_DELTA, ST_POS, ST_OUT
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_CAPTURE, OP_LOAD, OP_MUL_VMDT, OP_MUL_ADT, OP_TEST, OP_IDLE_TICK,
      OP_PICK, OP_MUL_SDT, OP_MUL_SS, OP_MUL_GG, OP_MUL_VV, OP_TG_GO, OP_TG_WAIT,
      OP_AD_GO, OP_AD_WAIT, OP_DD_GO, OP_DD_WAIT, OP_DECIDE, OP_MUL_ACC,
      OP_VEL_STEP, OP_VEL_NEW, OP_VSUM, OP_MUL_DELTA, OP_POS, OP_OUT
   } op_type;

   typedef struct packed {
      op_type op;
      logic   axis;
   } cmd_type;

   typedef struct packed {
      logic kind;
      logic motion;
      logic simple;
      logic div_done;
      logic rsp_busy;
   } status_type;

   function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
      if (x > 36'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (x < -36'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return $signed(x[31:0]);
      end
   endfunction

   function automatic logic [31:0] mag32(input logic signed [31:0] x);
      if (x[31]) begin
         return ~x + 32'd1;
      end else begin
         return x;
      end
   endfunction

endpackage

FILE: design/ttms_div.sv
// Restoring divider for squared-speed distances, quotient capped at 2^40.
module ttms_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [40:0] quotient
);
   import ttms_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [40:0] num_ff, num_in;
   logic [40:0] quo_ff, quo_in;
   logic [31:0] divisor_ff, divisor_in;
   logic [32:0] trial;

   assign trial = {rem_ff, num_ff[40]};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      num_in     = num_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (start) begin
         divisor_in = divisor;
         if ({9'b0, dividend[63:41]} >= divisor) begin
            quo_in  = DIST_CAP;
            done_in = 1'b1;
         end else begin
            rem_in  = {9'b0, dividend[63:41]};
            num_in  = dividend[40:0];
            quo_in  = '0;
            cnt_in  = 6'd40;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in = 32'(trial - {1'b0, divisor_ff});
            quo_in = {quo_ff[39:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[39:0], 1'b0};
         end
         num_in = {num_ff[39:0], 1'b0};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff     <= cnt_in;
      rem_ff     <= rem_in;
      num_ff     <= num_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign quotient = (quo_ff > DIST_CAP) ? DIST_CAP : quo_ff;

endmodule

FILE: design/ttms_dpath.sv
// Datapath: settings, axis state, shared multiplier, divider and result register.
module ttms_dpath (
   input  logic                 clock,
   input  logic                 reset,
   input  ttms_pkg::cmd_type    cmd,
   output ttms_pkg::status_type status,
   input  ttms_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ttms_pkg::rsp_type    rsp_data,
   input  logic                 csr_valid,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_data
);
   import ttms_pkg::*;

   logic [30:0] accel_limit_ff, decel_limit_ff, speed_limit_ff;
   logic [16:0] tick_length_ff;
   logic signed [31:0] remain_x_ff, remain_y_ff, vel_x_ff, vel_y_ff;
   logic signed [31:0] goal_x_ff, goal_y_ff;
   logic running_ff, complete_ff;
   req_type in_ff;
   logic [64:0] prod_ff;
   logic [31:0] vmdt_ff;
   logic [30:0] hadt_ff, hsdt_ff;
   logic [63:0] sqs_ff, sqg_ff, sqv_ff;
   logic [41:0] tg_ff, dd_ff;
   logic [40:0] ad_ff;
   logic signed [31:0] acc_x_ff, acc_y_ff, step_ff, vnew_ff;
   logic signed [32:0] sum_ff;
   logic mv_ff, fin_ff;
   rsp_type rsp_ff;
   logic rsp_valid_ff;

   logic signed [31:0] x1, v0, v1, acc_cur, alim, dlim, vm_s;
   logic [31:0] span, v0mag, gmag, vm32, smag, acc_mag, adt, dmag;
   logic [32:0] vdiff, sum_mag, tmag;
   logic vneg, dneg, v0_pos, opp, near, motion;
   logic signed [31:0] pick_acc, decide_acc, vsat, vclamp;
   logic [42:0] sum_ad;
   logic signed [35:0] step_wide, sdelta, npos_wide;
   logic [32:0] mul_a;
   logic [31:0] mul_b;
   logic mul_en, div_start, div_done;
   logic [63:0] div_dividend;
   logic [31:0] twoa;
   logic [40:0] div_q;

   function automatic logic [63:0] absdiff(input logic [63:0] p, input logic [63:0] q);
      if (p > q) begin
         return p - q;
      end else begin
         return q - p;
      end
   endfunction

   assign x1 = cmd.axis ? remain_y_ff : remain_x_ff;
   assign v0 = cmd.axis ? vel_y_ff : vel_x_ff;
   assign v1 = cmd.axis ? goal_y_ff : goal_x_ff;
   assign acc_cur = cmd.axis ? acc_y_ff : acc_x_ff;

   assign alim  = $signed({1'b0, accel_limit_ff});
   assign dlim  = $signed({1'b0, decel_limit_ff});
   assign vm_s  = $signed({1'b0, speed_limit_ff});
   assign vm32  = {1'b0, speed_limit_ff};
   assign span  = mag32(x1);
   assign v0mag = mag32(v0);
   assign gmag  = mag32(v1);
   assign smag  = (v0mag > vm32) ? vm32 : v0mag;
   assign vdiff = {v1[31], v1} - {v0[31], v0};
   assign vneg  = vdiff[32];
   assign dneg  = x1[31];
   assign v0_pos = !v0[31] && (v0 != 32'sd0);
   assign opp   = (x1[31] && v0_pos) || (!x1[31] && (x1 != 32'sd0) && v0[31]);
   assign near  = span <= vmdt_ff;
   assign adt   = prod_ff[47:16];
   assign motion = (mag32(remain_x_ff) > vmdt_ff) || (mag32(remain_y_ff) > vmdt_ff) ||
                   (mag32(vel_x_ff) > adt) || (mag32(vel_y_ff) > adt);
   assign acc_mag = mag32(acc_cur);
   assign sum_mag = sum_ff[32] ? (~sum_ff + 33'd1) : sum_ff;
   assign tmag    = prod_ff[48:16];
   assign dmag    = prod_ff[48:17];
   assign twoa    = (accel_limit_ff == 31'd0) ? 32'd2 : {accel_limit_ff, 1'b0};
   assign sum_ad  = {2'b0, ad_ff} + {1'b0, dd_ff};

   always_comb begin
      if (near) begin
         if (v0mag <= {1'b0, hadt_ff}) begin
            pick_acc = 32'sd0;
         end else begin
            pick_acc = vneg ? -dlim : dlim;
         end
      end else begin
         pick_acc = v0[31] ? dlim : -dlim;
      end
   end

   always_comb begin
      if (sum_ad < {11'b0, span}) begin
         decide_acc = (smag == vm32) ? 32'sd0 : (dneg ? -alim : alim);
      end else if (tg_ff >= {10'b0, span}) begin
         decide_acc = vneg ? -alim : alim;
      end else if (smag != vm32) begin
         decide_acc = dneg ? -alim : alim;
      end else begin
         decide_acc = 32'sd0;
      end
   end

   always_comb begin
      step_wide = acc_cur[31] ? -$signed({3'b0, tmag}) : $signed({3'b0, tmag});
      vsat = sat32({{4{v0[31]}}, v0} + {{4{step_ff[31]}}, step_ff});
      if (vsat > vm_s) begin
         vclamp = vm_s;
      end else if (vsat < -vm_s) begin
         vclamp = -vm_s;
      end else begin
         vclamp = vsat;
      end
      if (mag32(vclamp) < {1'b0, hadt_ff}) begin
         vclamp = 32'sd0;
      end
      sdelta = sum_ff[32] ? -$signed({4'b0, dmag}) : $signed({4'b0, dmag});
      npos_wide = {{4{x1[31]}}, x1} - sdelta;
   end

   always_comb begin
      mul_en = 1'b1;
      mul_a  = '0;
      mul_b  = '0;
      case (cmd.op)
         OP_MUL_VMDT: begin
            mul_a = {2'b0, speed_limit_ff};
            mul_b = {15'b0, tick_length_ff};
         end
         OP_MUL_ADT: begin
            mul_a = {2'b0, accel_limit_ff};
            mul_b = {15'b0, tick_length_ff};
         end
         OP_MUL_SDT: begin
            mul_a = {1'b0, smag};
            mul_b = {15'b0, tick_length_ff};
         end
         OP_MUL_SS: begin
            mul_a = {1'b0, smag};
            mul_b = smag;
         end
         OP_MUL_GG: begin
            mul_a = {1'b0, gmag};
            mul_b = gmag;
         end
         OP_MUL_VV: begin
            mul_a = {1'b0, vm32};
            mul_b = vm32;
         end
         OP_MUL_ACC: begin
            mul_a = {1'b0, acc_mag};
            mul_b = {15'b0, tick_length_ff};
         end
         OP_MUL_DELTA: begin
            mul_a = sum_mag;
            mul_b = {15'b0, tick_length_ff};
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      div_start    = 1'b1;
      div_dividend = '0;
      case (cmd.op)
         OP_TG_GO: div_dividend = absdiff(sqg_ff, sqs_ff);
         OP_AD_GO: div_dividend = absdiff(sqv_ff, sqs_ff);
         OP_DD_GO: div_dividend = absdiff(sqv_ff, sqg_ff);
         default:  div_start = 1'b0;
      endcase
   end

   ttms_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (twoa),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_limit_ff <= ACCEL_RESET;
         decel_limit_ff <= DECEL_RESET;
         speed_limit_ff <= SPEED_RESET;
         tick_length_ff <= TICK_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ACCEL_LIMIT: accel_limit_ff <= csr_data[30:0];
            CSR_DECEL_LIMIT: decel_limit_ff <= csr_data[30:0];
            CSR_SPEED_LIMIT: speed_limit_ff <= csr_data[30:0];
            CSR_TICK_LENGTH: tick_length_ff <= csr_data[16:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_x_ff  <= '0;
         remain_y_ff  <= '0;
         vel_x_ff     <= '0;
         vel_y_ff     <= '0;
         goal_x_ff    <= '0;
         goal_y_ff    <= '0;
         running_ff   <= 1'b0;
         complete_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (cmd.op)
            OP_LOAD: begin
               remain_x_ff <= in_ff.target_x;
               remain_y_ff <= in_ff.target_y;
               goal_x_ff   <= in_ff.final_speed_x;
               goal_y_ff   <= in_ff.final_speed_y;
            end
            OP_TEST: begin
               if (motion) begin
                  running_ff  <= 1'b1;
                  complete_ff <= 1'b0;
               end
            end
            OP_IDLE_TICK: begin
               if (running_ff) begin
                  complete_ff <= 1'b1;
                  running_ff  <= 1'b0;
               end
            end
            OP_POS: begin
               if (cmd.axis) begin
                  remain_y_ff <= sat32(npos_wide);
                  vel_y_ff    <= vnew_ff;
               end else begin
                  remain_x_ff <= sat32(npos_wide);
                  vel_x_ff    <= vnew_ff;
               end
            end
            default: ;
         endcase
         if (cmd.op == OP_OUT) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= mul_a * {1'b0, mul_b};
      end
      case (cmd.op)
         OP_CAPTURE: in_ff <= req_data;
         OP_LOAD: begin
            acc_x_ff <= '0;
            acc_y_ff <= '0;
            mv_ff    <= 1'b0;
            fin_ff   <= 1'b0;
         end
         OP_MUL_ADT: vmdt_ff <= prod_ff[47:16];
         OP_TEST: begin
            hadt_ff  <= adt[31:1];
            acc_x_ff <= '0;
            acc_y_ff <= '0;
            mv_ff    <= motion;
            fin_ff   <= 1'b0;
         end
         OP_IDLE_TICK: fin_ff <= running_ff;
         OP_PICK: begin
            if (cmd.axis) begin
               acc_y_ff <= pick_acc;
            end else begin
               acc_x_ff <= pick_acc;
            end
         end
         OP_MUL_SS: hsdt_ff <= prod_ff[47:17];
         OP_MUL_GG: sqs_ff <= prod_ff[63:0];
         OP_MUL_VV: sqg_ff <= prod_ff[63:0];
         OP_TG_GO:  sqv_ff <= prod_ff[63:0];
         OP_TG_WAIT: begin
            if (div_done) begin
               tg_ff <= {1'b0, div_q} + {11'b0, hsdt_ff};
            end
         end
         OP_AD_WAIT: begin
            if (div_done) begin
               ad_ff <= div_q;
            end
         end
         OP_DD_WAIT: begin
            if (div_done) begin
               dd_ff <= {1'b0, div_q} + {11'b0, hsdt_ff};
            end
         end
         OP_DECIDE: begin
            if (cmd.axis) begin
               acc_y_ff <= decide_acc;
            end else begin
               acc_x_ff <= decide_acc;
            end
         end
         OP_VEL_STEP: step_ff <= sat32(step_wide);
         OP_VEL_NEW:  vnew_ff <= vclamp;
         OP_VSUM:     sum_ff <= {vnew_ff[31], vnew_ff} + {v0[31], v0};
         OP_OUT: begin
            rsp_ff.accel_x  <= acc_x_ff;
            rsp_ff.accel_y  <= acc_y_ff;
            rsp_ff.speed_x  <= vel_x_ff;
            rsp_ff.speed_y  <= vel_y_ff;
            rsp_ff.left_x   <= remain_x_ff;
            rsp_ff.left_y   <= remain_y_ff;
            rsp_ff.moving   <= mv_ff;
            rsp_ff.finished <= fin_ff;
         end
         default: ;
      endcase
   end

   assign status.kind     = in_ff.kind;
   assign status.motion   = motion;
   assign status.simple   = near || opp;
   assign status.div_done = div_done;
   assign status.rsp_busy = rsp_valid_ff && rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: design/ttms_ctrl.sv
// Controller: sequences one item through the datapath, one axis after the other.
module ttms_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ttms_pkg::status_type status,
   output ttms_pkg::cmd_type    cmd
);
   import ttms_pkg::*;

   state_type state_ff, state_in;
   logic      axis_ff, axis_in;

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_DECODE;
         ST_DECODE:    state_in = (status.kind == KIND_LOAD) ? ST_LOAD : ST_MUL_VMDT;
         ST_LOAD:      state_in = ST_OUT;
         ST_MUL_VMDT:  state_in = ST_MUL_ADT;
         ST_MUL_ADT:   state_in = ST_TEST;
         ST_TEST: begin
            axis_in  = 1'b0;
            state_in = status.motion ? ST_PICK : ST_IDLE_TICK;
         end
         ST_IDLE_TICK: state_in = ST_OUT;
         ST_PICK:      state_in = status.simple ? ST_MUL_ACC : ST_MUL_SDT;
         ST_MUL_SDT:   state_in = ST_MUL_SS;
         ST_MUL_SS:    state_in = ST_MUL_GG;
         ST_MUL_GG:    state_in = ST_MUL_VV;
         ST_MUL_VV:    state_in = ST_TG_GO;
         ST_TG_GO:     state_in = ST_TG_WAIT;
         ST_TG_WAIT:   if (status.div_done) state_in = ST_AD_GO;
         ST_AD_GO:     state_in = ST_AD_WAIT;
         ST_AD_WAIT:   if (status.div_done) state_in = ST_DD_GO;
         ST_DD_GO:     state_in = ST_DD_WAIT;
         ST_DD_WAIT:   if (status.div_done) state_in = ST_DECIDE;
         ST_DECIDE:    state_in = ST_MUL_ACC;
         ST_MUL_ACC:   state_in = ST_VEL_STEP;
         ST_VEL_STEP:  state_in = ST_VEL_NEW;
         ST_VEL_NEW:   state_in = ST_VSUM;
         ST_VSUM:      state_in = ST_MUL_DELTA;
         ST_MUL_DELTA: state_in = ST_POS;
         ST_POS: begin
            axis_in  = 1'b1;
            state_in = axis_ff ? ST_OUT : ST_PICK;
         end
         ST_OUT:       if (!status.rsp_busy) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.axis  = axis_ff;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE:      cmd.op = OP_CAPTURE;
         ST_LOAD:      cmd.op = OP_LOAD;
         ST_MUL_VMDT:  cmd.op = OP_MUL_VMDT;
         ST_MUL_ADT:   cmd.op = OP_MUL_ADT;
         ST_TEST:      cmd.op = OP_TEST;
         ST_IDLE_TICK: cmd.op = OP_IDLE_TICK;
         ST_PICK:      cmd.op = OP_PICK;
         ST_MUL_SDT:   cmd.op = OP_MUL_SDT;
         ST_MUL_SS:    cmd.op = OP_MUL_SS;
         ST_MUL_GG:    cmd.op = OP_MUL_GG;
         ST_MUL_VV:    cmd.op = OP_MUL_VV;
         ST_TG_GO:     cmd.op = OP_TG_GO;
         ST_TG_WAIT:   cmd.op = OP_TG_WAIT;
         ST_AD_GO:     cmd.op = OP_AD_GO;
         ST_AD_WAIT:   cmd.op = OP_AD_WAIT;
         ST_DD_GO:     cmd.op = OP_DD_GO;
         ST_DD_WAIT:   cmd.op = OP_DD_WAIT;
         ST_DECIDE:    cmd.op = OP_DECIDE;
         ST_MUL_ACC:   cmd.op = OP_MUL_ACC;
         ST_VEL_STEP:  cmd.op = OP_VEL_STEP;
         ST_VEL_NEW:   cmd.op = OP_VEL_NEW;
         ST_VSUM:      cmd.op = OP_VSUM;
         ST_MUL_DELTA: cmd.op = OP_MUL_DELTA;
         ST_POS:       cmd.op = OP_POS;
         ST_OUT:       cmd.op = status.rsp_busy ? OP_NONE : OP_OUT;
         default:      cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
      end
   end

endmodule

FILE: design/two_axis_trapezoid_motion_step.sv
// Top level of the two-axis trapezoid motion step.
//
// Input beats (req_) carry either a command (kind 0: distance to go and final
// speeds per axis) or a control tick (kind 1). Every input beat yields exactly
// one result beat (rsp_) with chosen accelerations, new speeds, remaining
// distances and the moving/finished flags. Settings are to be written on csr_
// while idle, which the block does not enforce; csr_ready is always high.
// One item at a time: req_stall is low only while the sequencer is idle.
// A command goes through decode and load. A tick with nothing to move runs
// decode, two multiplies, the motion test and the idle tick. A moving tick
// walks both axes through one shared 33x32 multiplier and one radix-2
// divider; an axis needing the full distance test runs three divisions,
// otherwise it skips them.
// A finished result waits in the output register while rsp_stall is high; the
// next input beat is still accepted, and its result waits for that register.
// Reset clears axis state and flags and restores the default settings.
module two_axis_trapezoid_motion_step (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ttms_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ttms_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_data
);
   import ttms_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   ttms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ttms_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

`ifndef ASSERT_OFF
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input beat accepted but sequencer not busy");

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (cmd.op == OP_TG_WAIT || cmd.op == OP_AD_WAIT ||
                           cmd.op == OP_DD_WAIT))
      else $error("divider finished outside a wait step");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.moving && rsp_data.finished))
      else $error("result beat both moving and finished");
`endif

endmodule
